// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl, included by the top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ===== rtl/segx_pkg.sv =====
// shared constants for the segment intersection pipeline
// no dependencies
`timescale 1ns / 1ps
package segx_pkg;
   localparam int unsigned WORD_W = 32;
   localparam int unsigned REQ_W = 8 * WORD_W;
   localparam int unsigned RSP_W = 72;
   localparam logic [WORD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0] SAT_NEG = 32'h8000_0000;
endpackage

// ===== rtl/segx_mul.sv =====
// two stage rounded fixed point multiply with saturation
// depends on segx_pkg
`timescale 1ns / 1ps
module segx_mul #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic clock,
   input  logic enable,
   input  logic [segx_pkg::WORD_W-1:0] a,
   input  logic [segx_pkg::WORD_W-1:0] b,
   output logic [segx_pkg::WORD_W-1:0] prod,
   output logic ovf
);
   import segx_pkg::*;
   logic neg;
   logic [WORD_W-1:0] ma, mb;
   logic [2*WORD_W-1:0] p_in, p_ff, q;
   logic neg_ff;
   logic [WORD_W-1:0] prod_in, prod_ff;
   logic ovf_in, ovf_ff;
   // magnitude product
   always_comb begin
      neg = a[WORD_W-1] ^ b[WORD_W-1];
      ma = a[WORD_W-1] ? (~a + 1'b1) : a;
      mb = b[WORD_W-1] ? (~b + 1'b1) : b;
      p_in = (2*WORD_W)'(ma) * (2*WORD_W)'(mb);
   end
   always_ff @(posedge clock) begin
      if (enable) begin
         p_ff <= p_in;
         neg_ff <= neg;
      end
   end
   // rounding and saturation
   always_comb begin
      q = (p_ff + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      ovf_in = 1'b0;
      if (!neg_ff) begin
         if (q > 64'h7FFF_FFFF) begin
            ovf_in = 1'b1;
            prod_in = SAT_POS;
         end else begin
            prod_in = q[WORD_W-1:0];
         end
      end else begin
         if (q > 64'h8000_0000) begin
            ovf_in = 1'b1;
            prod_in = SAT_NEG;
         end else begin
            prod_in = ~q[WORD_W-1:0] + 1'b1;
         end
      end
   end
   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
         ovf_ff <= ovf_in;
      end
   end
   assign prod = prod_ff;
   assign ovf = ovf_ff;
endmodule

// ===== rtl/segx_div.sv =====
// pipelined restoring divider, one quotient bit per stage, rounded and saturated
// depends on segx_pkg
`timescale 1ns / 1ps
module segx_div #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic clock,
   input  logic enable,
   input  logic [segx_pkg::WORD_W-1:0] num,
   input  logic [segx_pkg::WORD_W-1:0] den,
   output logic [segx_pkg::WORD_W-1:0] quo,
   output logic ovf
);
   import segx_pkg::*;
   // dividend (2|n| << F) + |d| over divisor 2|d|
   localparam int unsigned NW = WORD_W + FRAC_BITS + 2;
   localparam int unsigned DW = WORD_W + 1;
   logic [NW-1:0] rem_ff [NW+1];
   logic [NW-1:0] q_ff [NW+1];
   logic [DW-1:0] d_ff [NW+1];
   logic neg_ff [NW+1];
   logic neg;
   logic [WORD_W-1:0] mn, md;
   always_comb begin
      neg = num[WORD_W-1] ^ den[WORD_W-1];
      mn = num[WORD_W-1] ? (~num + 1'b1) : num;
      md = den[WORD_W-1] ? (~den + 1'b1) : den;
   end
   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= (NW'(mn) << (FRAC_BITS + 1)) + NW'(md);
         q_ff[0] <= '0;
         d_ff[0] <= {md, 1'b0};
         neg_ff[0] <= neg;
      end
   end
   for (genvar s = 0; s < NW; s++) begin : g_step
      localparam int unsigned SH = NW - 1 - s;
      logic [NW+DW-1:0] shd;
      logic take;
      always_comb begin
         shd = (NW+DW)'(d_ff[s]) << SH;
         take = (NW+DW)'(rem_ff[s]) >= shd;
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[s+1] <= take ? rem_ff[s] - shd[NW-1:0] : rem_ff[s];
            q_ff[s+1] <= q_ff[s] | (NW'(take) << SH);
            d_ff[s+1] <= d_ff[s];
            neg_ff[s+1] <= neg_ff[s];
         end
      end
   end
   always_comb begin
      ovf = 1'b0;
      if (!neg_ff[NW]) begin
         if (q_ff[NW] > NW'(64'h7FFF_FFFF)) begin
            ovf = 1'b1;
            quo = SAT_POS;
         end else begin
            quo = q_ff[NW][WORD_W-1:0];
         end
      end else begin
         if (q_ff[NW] > NW'(64'h8000_0000)) begin
            ovf = 1'b1;
            quo = SAT_NEG;
         end else begin
            quo = ~q_ff[NW][WORD_W-1:0] + 1'b1;
         end
      end
   end
endmodule

// ===== rtl/segment_intersection_q16.sv =====
// segment intersection top level: stream ports, pipeline control and datapath
// depends on segx_pkg, segx_mul, segx_div and assert_macros.svh
`timescale 1ns / 1ps
// usage
//   a request carries two segments, eight signed fixed point words, on req_tdata
//   one response per request on rsp_tdata: hit, crossing x and y, overflow
//   from request handshake to the earliest response handshake a request passes
//   four stages ahead of the divider, WORD_W + FRAC_BITS + 3 divider stages
//   and four stages after it
//   one request per cycle is taken while the pipeline is moving
//   the divider settles one quotient bit per stage, which sets most of the latency
//   the whole pipeline advances together; a stall at rsp_tready freezes every
//   stage and holds the output register, nothing is lost or repeated
//   req_tready is high when the output register is empty or being taken
//   reset clears all valid bits; data registers are not reset
//   stages: differences, cross products, numerators and denominator,
//   divider, range test, point products, final sums
module segment_intersection_q16 #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
   input  logic [segx_pkg::REQ_W-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // hit, cross_x, cross_y, overflow, zero fill
   output logic [segx_pkg::RSP_W-1:0] rsp_tdata
);
   import segx_pkg::*;
   `include "assert_macros.svh"
   localparam int unsigned DIV_LAT = WORD_W + FRAC_BITS + 3;
   localparam int unsigned LAT = DIV_LAT + 8;
   localparam logic [WORD_W-1:0] ONE = WORD_W'(1) << FRAC_BITS;

   logic en;
   logic [LAT-1:0] vld_ff, vld_in;
   assign en = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[LAT-1];
   always_comb vld_in = {vld_ff[LAT-2:0], req_tvalid};
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // stage 1: differences
   logic [WORD_W-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
   assign {y4, x4, y3, x3, y2, x2, y1, x1} = req_tdata;
   logic [WORD_W-1:0] dxa_ff, dya_ff, dxb_ff, dyb_ff, dx13_ff, dy13_ff, x1_ff, y1_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         dxa_ff <= x2 - x1;
         dya_ff <= y2 - y1;
         dxb_ff <= x4 - x3;
         dyb_ff <= y4 - y3;
         dx13_ff <= x1 - x3;
         dy13_ff <= y1 - y3;
         x1_ff <= x1;
         y1_ff <= y1;
      end
   end

   // stage 2: six cross products
   logic [WORD_W-1:0] p [6];
   logic [5:0] po;
   segx_mul #(.FRAC_BITS(FRAC_BITS)) u_m0 (.clock, .enable(en), .a(dxb_ff), .b(dy13_ff),
      .prod(p[0]), .ovf(po[0]));
   segx_mul #(.FRAC_BITS(FRAC_BITS)) u_m1 (.clock, .enable(en), .a(dyb_ff), .b(dx13_ff),
      .prod(p[1]), .ovf(po[1]));
   segx_mul #(.FRAC_BITS(FRAC_BITS)) u_m2 (.clock, .enable(en), .a(dxa_ff), .b(dy13_ff),
      .prod(p[2]), .ovf(po[2]));
   segx_mul #(.FRAC_BITS(FRAC_BITS)) u_m3 (.clock, .enable(en), .a(dya_ff), .b(dx13_ff),
      .prod(p[3]), .ovf(po[3]));
   segx_mul #(.FRAC_BITS(FRAC_BITS)) u_m4 (.clock, .enable(en), .a(dyb_ff), .b(dxa_ff),
      .prod(p[4]), .ovf(po[4]));
   segx_mul #(.FRAC_BITS(FRAC_BITS)) u_m5 (.clock, .enable(en), .a(dxb_ff), .b(dya_ff),
      .prod(p[5]), .ovf(po[5]));
   logic [WORD_W-1:0] c2_dxa_ff, c2_dya_ff, c2_x1_ff, c2_y1_ff;
   logic [WORD_W-1:0] c2b_dxa_ff, c2b_dya_ff, c2b_x1_ff, c2b_y1_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         c2_dxa_ff <= dxa_ff;
         c2_dya_ff <= dya_ff;
         c2_x1_ff <= x1_ff;
         c2_y1_ff <= y1_ff;
         c2b_dxa_ff <= c2_dxa_ff;
         c2b_dya_ff <= c2_dya_ff;
         c2b_x1_ff <= c2_x1_ff;
         c2b_y1_ff <= c2_y1_ff;
      end
   end

   // stage 3: numerators and denominator
   logic [WORD_W-1:0] na_ff, nb_ff, den_ff;
   logic ov3_ff;
   logic [WORD_W-1:0] c3_dxa_ff, c3_dya_ff, c3_x1_ff, c3_y1_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         na_ff <= p[0] - p[1];
         nb_ff <= p[2] - p[3];
         den_ff <= p[4] - p[5];
         ov3_ff <= |po;
         c3_dxa_ff <= c2b_dxa_ff;
         c3_dya_ff <= c2b_dya_ff;
         c3_x1_ff <= c2b_x1_ff;
         c3_y1_ff <= c2b_y1_ff;
      end
   end

   // divider stages, side data delayed alongside
   logic [WORD_W-1:0] ua, ub;
   logic ua_ov, ub_ov;
   segx_div #(.FRAC_BITS(FRAC_BITS)) u_da (.clock, .enable(en), .num(na_ff), .den(den_ff),
      .quo(ua), .ovf(ua_ov));
   segx_div #(.FRAC_BITS(FRAC_BITS)) u_db (.clock, .enable(en), .num(nb_ff), .den(den_ff),
      .quo(ub), .ovf(ub_ov));
   localparam int unsigned SD = DIV_LAT;
   logic [4*WORD_W+1:0] sd_ff [SD];
   always_ff @(posedge clock) begin
      if (en) begin
         sd_ff[0] <= {ov3_ff, den_ff == '0, c3_dxa_ff, c3_dya_ff, c3_x1_ff, c3_y1_ff};
         for (int i = 1; i < SD; i++) sd_ff[i] <= sd_ff[i-1];
      end
   end
   logic d_ov, d_zero;
   logic [WORD_W-1:0] d_dxa, d_dya, d_x1, d_y1;
   assign {d_ov, d_zero, d_dxa, d_dya, d_x1, d_y1} = sd_ff[SD-1];

   // range test
   logic [WORD_W-1:0] ua_ff, dxa4_ff, dya4_ff, x14_ff, y14_ff;
   logic hit4_ff, ov4_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         ua_ff <= ua;
         hit4_ff <= !d_zero && !ua[WORD_W-1] && ($signed(ua) <= $signed(ONE))
            && !ub[WORD_W-1] && ($signed(ub) <= $signed(ONE));
         ov4_ff <= d_ov || (!d_zero && (ua_ov || ub_ov));
         dxa4_ff <= d_dxa;
         dya4_ff <= d_dya;
         x14_ff <= d_x1;
         y14_ff <= d_y1;
      end
   end

   // point products
   logic [WORD_W-1:0] px, py;
   logic pxo, pyo;
   segx_mul #(.FRAC_BITS(FRAC_BITS)) u_mx (.clock, .enable(en), .a(ua_ff), .b(dxa4_ff),
      .prod(px), .ovf(pxo));
   segx_mul #(.FRAC_BITS(FRAC_BITS)) u_my (.clock, .enable(en), .a(ua_ff), .b(dya4_ff),
      .prod(py), .ovf(pyo));
   logic [1:0] hit5_ff, ov5_ff;
   logic [WORD_W-1:0] x15_ff [2];
   logic [WORD_W-1:0] y15_ff [2];
   always_ff @(posedge clock) begin
      if (en) begin
         hit5_ff <= {hit5_ff[0], hit4_ff};
         ov5_ff <= {ov5_ff[0], ov4_ff};
         x15_ff[0] <= x14_ff;
         x15_ff[1] <= x15_ff[0];
         y15_ff[0] <= y14_ff;
         y15_ff[1] <= y15_ff[0];
      end
   end

   // final sums into the output register
   logic [RSP_W-1:0] out_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= {6'd0, ov5_ff[1] || (hit5_ff[1] && (pxo || pyo)),
            hit5_ff[1] ? y15_ff[1] + py : '0, hit5_ff[1] ? x15_ff[1] + px : '0, hit5_ff[1]};
      end
   end
   assign rsp_tdata = out_ff;

   logic rsp_stall;
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   `ASSERT_NEXT(a_stall_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))
   `ASSERT_IMPLIES(a_ready, clock, reset, !rsp_tvalid, req_tready)
   `ASSERT_IMPLIES(a_miss_zero, clock, reset, rsp_tvalid && !rsp_tdata[0], rsp_tdata[64:1] == '0)
endmodule
